### rtl/assert_macros.svh
// Shared assertion macros, clocked on the rising edge and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/wfg_pkg.sv
package wfg_pkg;

    localparam int OPCODE_W = 2;
    localparam int ID_W     = 4;

    localparam logic [OPCODE_W-1:0] OP_LOCK    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WAIT    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

endpackage

### rtl/wfg_if.sv
interface wfg_req_if;
    logic                          valid;
    logic                          ready;
    logic [wfg_pkg::OPCODE_W-1:0]  opcode;
    logic [wfg_pkg::ID_W-1:0]      thread_num;
    logic [wfg_pkg::ID_W-1:0]      resource_num;

    modport source (output valid, output opcode, output thread_num, output resource_num,
                    input ready);
    modport sink   (input valid, input opcode, input thread_num, input resource_num,
                    output ready);
endinterface

interface wfg_rsp_if;
    logic valid;
    logic ready;
    logic deadlock;

    modport source (output valid, output deadlock, input ready);
    modport sink   (input valid, input deadlock, output ready);
endinterface

### rtl/wfg_row_unit.sv
module wfg_row_unit #(
    parameter int THREADS   = 16,
    parameter int RESOURCES = 16,
    parameter int TW        = 4
) (
    input  logic [RESOURCES-1:0] i_wait_row,
    input  logic [RESOURCES-1:0] i_holder_valid,
    input  logic [TW-1:0]        i_holder_thread [RESOURCES],
    output logic [THREADS-1:0]   o_adj_row
);

    // Map each waited, held resource to an edge toward its holder.
    always_comb begin
        o_adj_row = '0;
        for (int r = 0; r < RESOURCES; r++) begin
            if (i_wait_row[r] && i_holder_valid[r]) begin
                o_adj_row[i_holder_thread[r]] = 1'b1;
            end
        end
    end

endmodule

### rtl/wait_for_graph_deadlock_detector.sv
// Wait-for graph deadlock detector.
// i_req carries one request: opcode (lock, wait, release), thread_num and
// resource_num. o_rsp returns one deadlock flag per request, in order, set
// when some chain of waiting threads leads back to a thread in it.
// The lock table and wait bitmaps change at the edge that accepts the
// request. The block then builds one adjacency row per cycle with a shared
// row unit (S_BUILD) and peels threads with no live successor, one pass per
// cycle (S_PEEL). In S_DONE the flag lands in the output register once it is
// free; only then does the block return to ready and take the next request.
// A finished flag waits in the output register while the next request is
// processed; if the receiver still stalls when that one finishes, the block
// holds in its final state until the register frees.
// Reset (synchronous, active low) frees every resource, clears all waits,
// drops any pending flag and returns the block to ready.
`include "assert_macros.svh"

module wait_for_graph_deadlock_detector #(
    parameter int THREADS   = 16,
    parameter int RESOURCES = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wfg_req_if.sink   i_req,
    wfg_rsp_if.source o_rsp
);

    localparam int TW = $clog2(THREADS);
    localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

    typedef enum logic [1:0] {S_IDLE, S_BUILD, S_PEEL, S_DONE} t_state;

    t_state               r_state;
    logic [TW-1:0]        r_cnt;
    logic [RESOURCES-1:0] r_holder_valid;
    logic [TW-1:0]        r_holder_thread [RESOURCES];
    logic [RESOURCES-1:0] r_wait [THREADS];
    logic [THREADS-1:0]   r_adj [THREADS];
    logic [THREADS-1:0]   r_alive;
    logic                 r_out_valid;
    logic                 r_out_deadlock;

    logic                 w_accept;
    logic                 w_in_range;
    logic [TW-1:0]        w_thr;
    logic [RW-1:0]        w_res;
    logic [THREADS-1:0]   w_adj_row;
    logic [THREADS-1:0]   n_alive;
    logic                 w_out_free;

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.deadlock = r_out_deadlock;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_in_range = (7'(i_req.thread_num) < 7'(THREADS)) &&
                        (7'(i_req.resource_num) < 7'(RESOURCES));
    assign w_thr      = TW'(i_req.thread_num);
    assign w_res      = RW'(i_req.resource_num);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    wfg_row_unit #(
        .THREADS   (THREADS),
        .RESOURCES (RESOURCES),
        .TW        (TW)
    ) u_row (
        .i_wait_row      (r_wait[r_cnt]),
        .i_holder_valid  (r_holder_valid),
        .i_holder_thread (r_holder_thread),
        .o_adj_row       (w_adj_row)
    );

    // Keep a thread only while it still points at a live thread.
    always_comb begin
        for (int t = 0; t < THREADS; t++) begin
            n_alive[t] = r_alive[t] && (|(r_adj[t] & r_alive));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_holder_valid <= '0;
            r_out_valid    <= 1'b0;
            for (int t = 0; t < THREADS; t++) begin
                r_wait[t] <= '0;
            end
        end else begin
            if (o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_in_range) begin
                            case (i_req.opcode)
                                wfg_pkg::OP_LOCK: begin
                                    r_holder_valid[w_res] <= 1'b1;
                                    r_wait[w_thr][w_res]  <= 1'b0;
                                end
                                wfg_pkg::OP_WAIT: begin
                                    r_wait[w_thr][w_res] <= 1'b1;
                                end
                                wfg_pkg::OP_RELEASE: begin
                                    if (r_holder_valid[w_res] &&
                                        r_holder_thread[w_res] == w_thr) begin
                                        r_holder_valid[w_res] <= 1'b0;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        r_cnt   <= '0;
                        r_state <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    if (r_cnt == TW'(THREADS - 1)) begin
                        r_cnt   <= '0;
                        r_alive <= '1;
                        r_state <= S_PEEL;
                    end else begin
                        r_cnt <= r_cnt + TW'(1);
                    end
                end
                S_PEEL: begin
                    r_alive <= n_alive;
                    if (r_cnt == TW'(THREADS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + TW'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_deadlock <= |r_alive;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_range && i_req.opcode == wfg_pkg::OP_LOCK) begin
            r_holder_thread[w_res] <= w_thr;
        end
        if (r_state == S_BUILD) begin
            r_adj[r_cnt] <= w_adj_row;
        end
    end

    `ASSERT_NEXT(a_accept_starts_build, i_clk, i_rst_n, w_accept,
        r_state == S_BUILD && r_cnt == '0)
    `ASSERT_NEXT(a_peel_only_drops, i_clk, i_rst_n, r_state == S_PEEL,
        (r_alive & ~$past(r_alive)) == '0)
    `ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, r_state == S_DONE && w_out_free,
        o_rsp.valid && r_state == S_IDLE)

endmodule

### sim/tb_top.sv
module tb_top;

    localparam int OPCODE_W      = wfg_pkg::OPCODE_W;
    localparam int ID_W          = wfg_pkg::ID_W;
    localparam int NUM_THREADS   = 16;
    localparam int NUM_RESOURCES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * NUM_THREADS + 8;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    wfg_req_if req_if ();
    wfg_rsp_if rsp_if ();

    wait_for_graph_deadlock_detector #(
        .THREADS   (NUM_THREADS),
        .RESOURCES (NUM_RESOURCES)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Mirror of the lock table and wait bitmaps
    bit                         holder_ok   [NUM_RESOURCES];
    logic [ID_W-1:0]            holder_tid  [NUM_RESOURCES];
    logic [NUM_RESOURCES-1:0]   wait_map    [NUM_THREADS];

    bit              deadlock_q [$];
    bit              expected_flag;
    int              error_count;
    int              cycle_count;
    bit              calm;
    logic [ID_W-1:0] chain_threads   [NUM_THREADS];
    logic [ID_W-1:0] chain_resources [NUM_RESOURCES];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(negedge clk) begin
        rsp_if.ready = calm || ($urandom_range(99) >= 17);
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (deadlock_q.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected deadlock response: got %0b", rsp_if.deadlock);
            end else begin
                expected_flag = deadlock_q.pop_front();
                if (rsp_if.deadlock !== expected_flag) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("deadlock mismatch: expected %0b got %0b",
                                 expected_flag, rsp_if.deadlock);
                end
            end
        end
    end

    function automatic bit circular_wait_exists();
        logic [NUM_THREADS-1:0] reach [NUM_THREADS];
        for (int t = 0; t < NUM_THREADS; t++) begin
            reach[t] = '0;
            for (int r = 0; r < NUM_RESOURCES; r++)
                if (wait_map[t][r] && holder_ok[r])
                    reach[t][holder_tid[r]] = 1'b1;
        end
        for (int k = 0; k < NUM_THREADS; k++)
            for (int i = 0; i < NUM_THREADS; i++)
                if (reach[i][k])
                    reach[i] |= reach[k];
        for (int t = 0; t < NUM_THREADS; t++)
            if (reach[t][t])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void apply_lock_event(input logic [OPCODE_W-1:0] op,
                                             input logic [ID_W-1:0] tid,
                                             input logic [ID_W-1:0] rid);
        case (op)
            wfg_pkg::OP_LOCK: begin
                holder_ok[rid]     = 1'b1;
                holder_tid[rid]    = tid;
                wait_map[tid][rid] = 1'b0;
            end
            wfg_pkg::OP_WAIT: begin
                wait_map[tid][rid] = 1'b1;
            end
            wfg_pkg::OP_RELEASE: begin
                if (holder_ok[rid] && holder_tid[rid] == tid)
                    holder_ok[rid] = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic issue_request(input logic [OPCODE_W-1:0] op,
                                 input logic [ID_W-1:0] tid,
                                 input logic [ID_W-1:0] rid);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 17) begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid        = 1'b1;
        req_if.opcode       = op;
        req_if.thread_num   = tid;
        req_if.resource_num = rid;
        do
            @(posedge clk);
        while (!req_if.ready);
        apply_lock_event(op, tid, rid);
        deadlock_q.push_back(circular_wait_exists());
    endtask

    task automatic wait_for_responses();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (deadlock_q.size() != 0)
            @(posedge clk);
    endtask

    // Free every held resource; optionally clear every pending wait too
    task automatic clear_lock_state(input bit clear_waits);
        for (int r = 0; r < NUM_RESOURCES; r++)
            if (holder_ok[r])
                issue_request(wfg_pkg::OP_RELEASE, holder_tid[r], r[ID_W-1:0]);
        if (clear_waits) begin
            for (int t = 0; t < NUM_THREADS; t++)
                for (int r = 0; r < NUM_RESOURCES; r++)
                    if (wait_map[t][r]) begin
                        issue_request(wfg_pkg::OP_LOCK, t[ID_W-1:0], r[ID_W-1:0]);
                        issue_request(wfg_pkg::OP_RELEASE, t[ID_W-1:0], r[ID_W-1:0]);
                    end
        end
    endtask

    task automatic send_random_event();
        logic [OPCODE_W-1:0] op;
        logic [ID_W-1:0]     tid;
        logic [ID_W-1:0]     rid;
        int                  roll;
        roll = $urandom_range(9);
        tid  = ID_W'($urandom_range(NUM_THREADS - 1));
        rid  = ID_W'($urandom_range(NUM_RESOURCES - 1));
        if (roll < 4)
            op = wfg_pkg::OP_LOCK;
        else if (roll < 7)
            op = wfg_pkg::OP_WAIT;
        else if (roll < 9)
            op = wfg_pkg::OP_RELEASE;
        else
            op = OP_UNUSED;
        if (op == wfg_pkg::OP_RELEASE && holder_ok[rid] && $urandom_range(1))
            tid = holder_tid[rid];
        issue_request(op, tid, rid);
    endtask

    task automatic shuffle_ids(inout logic [ID_W-1:0] ids [16]);
        logic [ID_W-1:0] tmp;
        int              j;
        for (int i = 0; i < 16; i++)
            ids[i] = i[ID_W-1:0];
        for (int i = 15; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = ids[i];
            ids[i]  = ids[j];
            ids[j]  = tmp;
        end
    endtask

    task automatic check_directed_cases();
        issue_request(wfg_pkg::OP_RELEASE, 4'd3,  4'd7);
        issue_request(wfg_pkg::OP_LOCK,    4'd0,  4'd0);
        issue_request(wfg_pkg::OP_WAIT,    4'd0,  4'd0);
        issue_request(OP_UNUSED,           4'd5,  4'd9);
        issue_request(wfg_pkg::OP_LOCK,    4'd0,  4'd0);
        issue_request(wfg_pkg::OP_RELEASE, 4'd1,  4'd0);
        issue_request(wfg_pkg::OP_RELEASE, 4'd0,  4'd0);
        issue_request(wfg_pkg::OP_RELEASE, 4'd0,  4'd0);
        issue_request(wfg_pkg::OP_LOCK,    4'd15, 4'd15);
        issue_request(wfg_pkg::OP_LOCK,    4'd1,  4'd1);
        issue_request(wfg_pkg::OP_WAIT,    4'd15, 4'd1);
        issue_request(wfg_pkg::OP_WAIT,    4'd1,  4'd15);
        issue_request(OP_UNUSED,           4'd15, 4'd15);
        issue_request(wfg_pkg::OP_LOCK,    4'd2,  4'd15);
        issue_request(wfg_pkg::OP_WAIT,    4'd2,  4'd1);
        issue_request(wfg_pkg::OP_RELEASE, 4'd15, 4'd15);
        issue_request(wfg_pkg::OP_RELEASE, 4'd1,  4'd1);
        issue_request(OP_UNUSED,           4'd0,  4'd0);
        clear_lock_state(1'b1);
    endtask

    task automatic run_chain_episode();
        int k;
        int j;
        bit close_loop;
        k          = $urandom_range(1, 6);
        close_loop = 1'($urandom_range(1));
        shuffle_ids(chain_threads);
        shuffle_ids(chain_resources);
        for (int i = 0; i < k; i++) begin
            issue_request(wfg_pkg::OP_LOCK, chain_threads[i], chain_resources[i]);
            if ($urandom_range(99) < 15)
                send_random_event();
        end
        for (int i = 0; i < k - 1; i++) begin
            issue_request(wfg_pkg::OP_WAIT, chain_threads[i], chain_resources[i+1]);
            if ($urandom_range(99) < 15)
                send_random_event();
        end
        if (close_loop)
            issue_request(wfg_pkg::OP_WAIT, chain_threads[k-1], chain_resources[0]);
        // In one episode of three, try to break the chain at one link, by release or by a new holder
        if ($urandom_range(2) == 0) begin
            j = $urandom_range(k - 1);
            if ($urandom_range(1))
                issue_request(wfg_pkg::OP_RELEASE, chain_threads[j], chain_resources[j]);
            else
                issue_request(wfg_pkg::OP_LOCK, ID_W'($urandom_range(NUM_THREADS - 1)),
                              chain_resources[j]);
        end
        clear_lock_state(1'($urandom_range(1)));
    endtask

    task automatic check_lock_chains();
        for (int e = 0; e < 40; e++) begin
            if (e == 10) begin
                wait_for_responses();
                calm = 1'b1;
            end
            if (e == 20)
                calm = 1'b0;
            run_chain_episode();
        end
        clear_lock_state(1'b1);
    endtask

    task automatic check_random_events();
        for (int n = 0; n < 150; n++) begin
            send_random_event();
            if (n % 20 == 19)
                clear_lock_state(1'b1);
        end
        clear_lock_state(1'b1);
    endtask

    initial begin
        rst_n               = 1'b0;
        calm                = 1'b0;
        error_count         = 0;
        cycle_count         = 0;
        req_if.valid        = 1'b0;
        req_if.opcode       = wfg_pkg::OP_LOCK;
        req_if.thread_num   = '0;
        req_if.resource_num = '0;
        rsp_if.ready        = 1'b0;
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            holder_ok[r]  = 1'b0;
            holder_tid[r] = '0;
        end
        for (int t = 0; t < NUM_THREADS; t++)
            wait_map[t] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_directed_cases();
        wait_for_responses();
        check_lock_chains();
        check_random_events();
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && deadlock_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/wfg_pkg.sv
rtl/wfg_if.sv
rtl/wfg_row_unit.sv
rtl/wait_for_graph_deadlock_detector.sv
sim/tb_top.sv
